/* hdl/rect_affine_bounding_box_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the affine bounding box block
// Immediate-style wrappers around concurrent properties; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef RECT_AFFINE_BOUNDING_BOX_TOP_ASSERT_SVH
`define RECT_AFFINE_BOUNDING_BOX_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RAB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rab assertion failed");
// next-cycle implication
`define RAB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rab assertion failed");
`else
`define RAB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RAB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hdl/rab_pkg.sv */
// ---------------------------------------------------------------------------
// rab_pkg
// Types and constants shared by the affine bounding box pipeline.
// ---------------------------------------------------------------------------
package rab_pkg;

  localparam int QFrac  = 16;
  localparam int ProdW  = 64;
  localparam int SumW   = 66;
  localparam int CoordW = 52;
  localparam int SpanW  = CoordW + 1;

  typedef logic signed [31:0]       coef_t;
  typedef logic        [30:0]       size_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [SpanW-1:0]  span_t;

  typedef struct packed {
    coef_t rect_x;
    coef_t rect_y;
    size_t rect_w;
    size_t rect_h;
    logic  rect_inf;
  } in_t;

  typedef struct packed {
    coef_t box_x;
    coef_t box_y;
    size_t box_w;
    size_t box_h;
    logic  box_inf;
    logic  clipped;
  } out_t;

  // partial products of one output axis
  typedef struct packed {
    prod_t ax;
    prod_t aw;
    prod_t by;
    prod_t bh;
  } prod_set_t;

endpackage

/* hdl/rab_mul.sv */
// ---------------------------------------------------------------------------
// rab_mul
// Multiply stage: four 32x32 signed products for one output axis.
// ---------------------------------------------------------------------------
module rab_mul (
  input  logic               clk,
  input  rab_pkg::coef_t     coef_a,
  input  rab_pkg::coef_t     coef_b,
  input  rab_pkg::coef_t     pos_a,
  input  rab_pkg::coef_t     pos_b,
  input  rab_pkg::size_t     size_a,
  input  rab_pkg::size_t     size_b,
  output rab_pkg::prod_set_t prod_r
);
  import rab_pkg::*;

  prod_set_t prod_nxt;

  // the far corner is split by linearity: a*(x+w) = a*x + a*w
  always_comb begin
    prod_nxt.ax = coef_a * pos_a;
    prod_nxt.aw = coef_a * $signed({1'b0, size_a});
    prod_nxt.by = coef_b * pos_b;
    prod_nxt.bh = coef_b * $signed({1'b0, size_b});
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* hdl/rab_corner.sv */
// ---------------------------------------------------------------------------
// rab_corner
// Sum stages: build the four mapped corners of one axis, round, translate.
// ---------------------------------------------------------------------------
module rab_corner (
  input  logic               clk,
  input  rab_pkg::prod_set_t prod,
  input  rab_pkg::coef_t     shift,
  output rab_pkg::coord_t    coord_r [4]
);
  import rab_pkg::*;

  localparam sum_t RoundHalf = sum_t'(1 << (QFrac - 1));

  sum_t   base_nxt;
  sum_t   awbh_nxt;
  sum_t   base_r;
  sum_t   aw_r;
  sum_t   bh_r;
  sum_t   awbh_r;
  sum_t   c_nxt [4];
  sum_t   c_r   [4];
  coord_t coord_nxt [4];

  // fold the rounding half into the base corner once
  always_comb begin
    base_nxt = sum_t'(prod.ax) + sum_t'(prod.by) + RoundHalf;
    awbh_nxt = sum_t'(prod.aw) + sum_t'(prod.bh);
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    aw_r   <= sum_t'(prod.aw);
    bh_r   <= sum_t'(prod.bh);
    awbh_r <= awbh_nxt;
  end

  always_comb begin
    c_nxt[0] = base_r;
    c_nxt[1] = base_r + aw_r;
    c_nxt[2] = base_r + bh_r;
    c_nxt[3] = base_r + awbh_r;
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
  end

  // arithmetic shift floors, which with the half added rounds ties up
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      coord_nxt[k] = coord_t'(c_r[k] >>> QFrac) + coord_t'(shift);
    end
  end

  always_ff @(posedge clk) begin
    coord_r <= coord_nxt;
  end

endmodule

/* hdl/rab_extent.sv */
// ---------------------------------------------------------------------------
// rab_extent
// Extent stages: min/max of four corners, then size and saturation.
// ---------------------------------------------------------------------------
module rab_extent (
  input  logic            clk,
  input  rab_pkg::coord_t coord [4],
  input  logic            force_zero,
  output rab_pkg::coef_t  pos_r,
  output rab_pkg::size_t  size_r,
  output logic            clip_r
);
  import rab_pkg::*;

  localparam coef_t PosMax = 32'sh7FFF_FFFF;
  localparam coef_t PosMin = 32'sh8000_0000;

  coord_t mn01;
  coord_t mn23;
  coord_t mx01;
  coord_t mx23;
  coord_t mn_nxt;
  coord_t mx_nxt;
  coord_t mn_r;
  coord_t mx_r;
  span_t  span;
  logic   pos_ovf;
  logic   size_ovf;
  coef_t  pos_nxt;
  size_t  size_nxt;

  always_comb begin
    mn01   = (coord[1] < coord[0]) ? coord[1] : coord[0];
    mn23   = (coord[3] < coord[2]) ? coord[3] : coord[2];
    mx01   = (coord[1] > coord[0]) ? coord[1] : coord[0];
    mx23   = (coord[3] > coord[2]) ? coord[3] : coord[2];
    mn_nxt = (mn23 < mn01) ? mn23 : mn01;
    mx_nxt = (mx23 > mx01) ? mx23 : mx01;
  end

  always_ff @(posedge clk) begin
    mn_r <= mn_nxt;
    mx_r <= mx_nxt;
  end

  // size comes from the unsaturated extremes, so it is never negative
  always_comb begin
    span     = span_t'(mx_r) - span_t'(mn_r);
    pos_ovf  = !((&mn_r[CoordW-1:31]) || !(|mn_r[CoordW-1:31]));
    size_ovf = |span[SpanW-1:31];
    pos_nxt  = pos_ovf ? (mn_r[CoordW-1] ? PosMin : PosMax) : mn_r[31:0];
    size_nxt = size_ovf ? '1 : span[30:0];
  end

  always_ff @(posedge clk) begin
    if (force_zero) begin
      pos_r  <= '0;
      size_r <= '0;
      clip_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      size_r <= size_nxt;
      clip_r <= pos_ovf | size_ovf;
    end
  end

endmodule

/* hdl/rect_affine_bounding_box_top.sv */
// A rectangle accepted on start passes through every pipeline register below and
// then shows its box on out_data with out_strobe high for one cycle.
// Throughput: one rectangle per cycle; busy stays low, the six-stage pipeline
// (multiply, two sum stages, translate, min/max, saturate) never backs up.
// Reset: synchronous, active low; clears the valid pipeline and restores the
// identity matrix with zero translation.
// ---------------------------------------------------------------------------
// rect_affine_bounding_box_top
// Bounding box of a rectangle mapped through a 2x3 affine matrix, Q16.16.
// ---------------------------------------------------------------------------
`include "rect_affine_bounding_box_top_assert.svh"

module rect_affine_bounding_box_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rab_pkg::in_t  in_data,
  output logic          out_strobe,
  output rab_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rab_pkg::*;

  localparam int Lat = 6;

  localparam logic [2:0] RegCoefXx = 3'd0;
  localparam logic [2:0] RegCoefXy = 3'd1;
  localparam logic [2:0] RegCoefYx = 3'd2;
  localparam logic [2:0] RegCoefYy = 3'd3;
  localparam logic [2:0] RegShiftX = 3'd4;
  localparam logic [2:0] RegShiftY = 3'd5;

  localparam coef_t QOne = 32'sh0001_0000;

  coef_t      coef_xx_r;
  coef_t      coef_xy_r;
  coef_t      coef_yx_r;
  coef_t      coef_yy_r;
  coef_t      shift_x_r;
  coef_t      shift_y_r;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cfg_wr_xx;

  logic           in_acc;
  logic [Lat:1]   v_r;
  logic [Lat:1]   v_nxt;
  logic [Lat:1]   inf_r;
  logic [Lat:1]   inf_nxt;

  prod_set_t prod_x;
  prod_set_t prod_y;
  coord_t    coord_x [4];
  coord_t    coord_y [4];
  coef_t     pos_x;
  coef_t     pos_y;
  size_t     size_x;
  size_t     size_y;
  logic      clip_x;
  logic      clip_y;
  logic      inf_zero;

  // ---- configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r <= QOne;
      coef_xy_r <= '0;
      coef_yx_r <= '0;
      coef_yy_r <= QOne;
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegCoefXx: coef_xx_r <= coef_t'(pwdata);
        RegCoefXy: coef_xy_r <= coef_t'(pwdata);
        RegCoefYx: coef_yx_r <= coef_t'(pwdata);
        RegCoefYy: coef_yy_r <= coef_t'(pwdata);
        RegShiftX: shift_x_r <= coef_t'(pwdata);
        RegShiftY: shift_y_r <= coef_t'(pwdata);
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegCoefXx: prdata = coef_xx_r;
      RegCoefXy: prdata = coef_xy_r;
      RegCoefYx: prdata = coef_yx_r;
      RegCoefYy: prdata = coef_yy_r;
      RegShiftX: prdata = shift_x_r;
      RegShiftY: prdata = shift_y_r;
      default:   prdata = '0;
    endcase
  end

  // ---- valid and infinite flags travel beside the data
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  always_comb begin
    v_nxt   = {v_r[Lat-1:1], in_acc};
    inf_nxt = {inf_r[Lat-1:1], in_data.rect_inf};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inf_r <= inf_nxt;
  end

  // ---- datapath, one lane per output axis
  rab_mul u_mul_x (
    .clk    (clk),
    .coef_a (coef_xx_r),
    .coef_b (coef_xy_r),
    .pos_a  (in_data.rect_x),
    .pos_b  (in_data.rect_y),
    .size_a (in_data.rect_w),
    .size_b (in_data.rect_h),
    .prod_r (prod_x)
  );

  rab_mul u_mul_y (
    .clk    (clk),
    .coef_a (coef_yx_r),
    .coef_b (coef_yy_r),
    .pos_a  (in_data.rect_x),
    .pos_b  (in_data.rect_y),
    .size_a (in_data.rect_w),
    .size_b (in_data.rect_h),
    .prod_r (prod_y)
  );

  rab_corner u_corner_x (
    .clk     (clk),
    .prod    (prod_x),
    .shift   (shift_x_r),
    .coord_r (coord_x)
  );

  rab_corner u_corner_y (
    .clk     (clk),
    .prod    (prod_y),
    .shift   (shift_y_r),
    .coord_r (coord_y)
  );

  // an infinite beat is zeroed in the last stage
  rab_extent u_extent_x (
    .clk        (clk),
    .coord      (coord_x),
    .force_zero (inf_r[Lat-1]),
    .pos_r      (pos_x),
    .size_r     (size_x),
    .clip_r     (clip_x)
  );

  rab_extent u_extent_y (
    .clk        (clk),
    .coord      (coord_y),
    .force_zero (inf_r[Lat-1]),
    .pos_r      (pos_y),
    .size_r     (size_y),
    .clip_r     (clip_y)
  );

  assign out_strobe       = v_r[Lat];
  assign out_data.box_x   = pos_x;
  assign out_data.box_y   = pos_y;
  assign out_data.box_w   = size_x;
  assign out_data.box_h   = size_y;
  assign out_data.box_inf = inf_r[Lat];
  assign out_data.clipped = clip_x | clip_y;

  // ---- checks
  assign cfg_wr_xx = cfg_wr && (cfg_idx == RegCoefXx);
  assign inf_zero  = (out_data.box_x == '0) && (out_data.box_y == '0) &&
                     (out_data.box_w == '0) && (out_data.box_h == '0) &&
                     !out_data.clipped;

  `RAB_ASSERT_IMP(a_strobe_from_accept, clk, rst_n, out_strobe, $past(in_acc, Lat))
  `RAB_ASSERT_IMP(a_inf_fields_zero, clk, rst_n, out_strobe && out_data.box_inf, inf_zero)
  `RAB_ASSERT_NXT(a_cfg_write_lands, clk, rst_n, cfg_wr_xx, coef_xx_r == $past(pwdata))

endmodule

/* tb/rab_tb_pkg.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rab_tb_pkg
// Register map of the affine bounding box block, shared by stimulus and checker.
// ---------------------------------------------------------------------------
package rab_tb_pkg;

  // register index; the byte address is four times the index
  typedef enum int {
    REG_COEF_XX,
    REG_COEF_XY,
    REG_COEF_YX,
    REG_COEF_YY,
    REG_SHIFT_X,
    REG_SHIFT_Y
  } cfg_reg_t;

  localparam int NUM_CFG_REGS = 6;

  localparam logic signed [31:0] Q_ONE = 32'sh10000;

endpackage

/* tb/rab_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rab_checker
// Tracks the matrix registers from bus writes, predicts the box of every
// accepted rectangle and compares each out_data beat with the oldest one.
// ---------------------------------------------------------------------------
module rab_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  rab_pkg::in_t  in_data,
  input  logic          out_strobe,
  input  rab_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  output int            fail_count,
  output int            boxes_waiting,
  output int            boxes_seen,
  output int            inf_seen,
  output int            clip_seen
);
  import rab_pkg::*;
  import rab_tb_pkg::*;

  // wide enough that no corner, product or sum wraps
  typedef logic signed [67:0] wide_t;

  localparam wide_t COORD_MAX  = 68'sd2147483647;
  localparam wide_t COORD_MIN  = -68'sd2147483648;
  localparam wide_t ROUND_HALF = 68'sd32768;

  coef_t matrix [NUM_CFG_REGS];
  out_t  box_fifo [$];
  int    faults;
  int    shown;
  int    n_boxes;
  int    n_inf;
  int    n_clip;

  // round to nearest with ties toward plus infinity, then translate
  function automatic wide_t map_axis(wide_t a, wide_t u, wide_t b, wide_t v, wide_t t);
    return ((a * u + b * v + ROUND_HALF) >>> QFrac) + t;
  endfunction

  function automatic wide_t clamp(wide_t v, wide_t lo, wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic out_t predict_box(in_t r);
    out_t  b;
    wide_t xs [2];
    wide_t ys [2];
    wide_t a_xx, a_xy, a_yx, a_yy, t_x, t_y;
    wide_t px, py, lo_x, hi_x, lo_y, hi_y;
    wide_t sx, sy, sw, sh;
    b = '0;
    if (r.rect_inf) begin
      b.box_inf = 1'b1;
      return b;
    end
    a_xx = matrix[REG_COEF_XX];
    a_xy = matrix[REG_COEF_XY];
    a_yx = matrix[REG_COEF_YX];
    a_yy = matrix[REG_COEF_YY];
    t_x  = matrix[REG_SHIFT_X];
    t_y  = matrix[REG_SHIFT_Y];
    xs[0] = signed'(r.rect_x);
    ys[0] = signed'(r.rect_y);
    xs[1] = xs[0] + {37'b0, r.rect_w};
    ys[1] = ys[0] + {37'b0, r.rect_h};
    lo_x = '0;
    hi_x = '0;
    lo_y = '0;
    hi_y = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        px = map_axis(a_xx, xs[i], a_xy, ys[j], t_x);
        py = map_axis(a_yx, xs[i], a_yy, ys[j], t_y);
        if ((i == 0 && j == 0) || px < lo_x) lo_x = px;
        if ((i == 0 && j == 0) || px > hi_x) hi_x = px;
        if ((i == 0 && j == 0) || py < lo_y) lo_y = py;
        if ((i == 0 && j == 0) || py > hi_y) hi_y = py;
      end
    end
    // sizes come from the unsaturated extremes
    sx = clamp(lo_x, COORD_MIN, COORD_MAX);
    sy = clamp(lo_y, COORD_MIN, COORD_MAX);
    sw = clamp(hi_x - lo_x, '0, COORD_MAX);
    sh = clamp(hi_y - lo_y, '0, COORD_MAX);
    b.box_x   = sx[31:0];
    b.box_y   = sy[31:0];
    b.box_w   = sw[30:0];
    b.box_h   = sh[30:0];
    b.clipped = (sx != lo_x) || (sy != lo_y) || (sw != hi_x - lo_x) || (sh != hi_y - lo_y);
    return b;
  endfunction

  always @(posedge clk) begin
    out_t  want;
    string bad;
    if (!rst_n) begin
      box_fifo.delete();
      matrix[REG_COEF_XX] = Q_ONE;
      matrix[REG_COEF_XY] = '0;
      matrix[REG_COEF_YX] = '0;
      matrix[REG_COEF_YY] = Q_ONE;
      matrix[REG_SHIFT_X] = '0;
      matrix[REG_SHIFT_Y] = '0;
    end else begin
      // writes above the last register are dropped by the block
      if (psel && penable && pwrite && pready && paddr[4:2] < NUM_CFG_REGS) begin
        matrix[paddr[4:2]] = pwdata;
      end
      if (out_strobe) begin
        if (box_fifo.size() == 0) begin
          faults++;
          if (shown < 10) begin
            shown++;
            $display("%0t: box beat with no rectangle pending: x=%h y=%h w=%h h=%h inf=%b clip=%b",
                     $realtime, out_data.box_x, out_data.box_y, out_data.box_w,
                     out_data.box_h, out_data.box_inf, out_data.clipped);
          end
        end else begin
          want = box_fifo.pop_front();
          bad = "";
          if (out_data.box_x !== want.box_x) bad = {bad, " box_x"};
          if (out_data.box_y !== want.box_y) bad = {bad, " box_y"};
          if (out_data.box_w !== want.box_w) bad = {bad, " box_w"};
          if (out_data.box_h !== want.box_h) bad = {bad, " box_h"};
          if (out_data.box_inf !== want.box_inf) bad = {bad, " box_inf"};
          if (out_data.clipped !== want.clipped) bad = {bad, " clipped"};
          if (bad != "") begin
            faults++;
            if (shown < 10) begin
              shown++;
              $display("%0t: box mismatch in%s", $realtime, bad);
              $display("  want x=%h y=%h w=%h h=%h inf=%b clip=%b",
                       want.box_x, want.box_y, want.box_w, want.box_h,
                       want.box_inf, want.clipped);
              $display("  got  x=%h y=%h w=%h h=%h inf=%b clip=%b",
                       out_data.box_x, out_data.box_y, out_data.box_w,
                       out_data.box_h, out_data.box_inf, out_data.clipped);
            end
          end
          n_boxes++;
          if (want.box_inf) n_inf++;
          if (want.clipped) n_clip++;
        end
      end
      if (start && !busy) begin
        box_fifo.push_back(predict_box(in_data));
      end
    end
    fail_count    <= faults;
    boxes_waiting <= box_fifo.size();
    boxes_seen    <= n_boxes;
    inf_seen      <= n_inf;
    clip_seen     <= n_clip;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives rectangles and matrix settings into the affine bounding box block:
// a directed set of corner cases, then random rectangles under a series of
// matrices with varied sender gaps; the checker judges every box beat.
// ---------------------------------------------------------------------------
module testbench;
  import rab_pkg::*;
  import rab_tb_pkg::*;

  localparam coef_t CMAX         = 32'sh7FFFFFFF;
  localparam coef_t CMIN         = 32'sh80000000;
  localparam size_t SMAX         = 31'h7FFFFFFF;
  localparam int    NUM_PHASES   = 12;
  localparam int    RECTS_PER_PH = 157;
  localparam int    IDLE_PCT [4] = '{0, 65, 0, 29};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_strobe;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int boxes_waiting;
  int boxes_seen;
  int inf_seen;
  int clip_seen;
  int n_rects;
  int n_settings;

  rect_affine_bounding_box_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  rab_checker box_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_strobe    (out_strobe),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .boxes_waiting (boxes_waiting),
    .boxes_seen    (boxes_seen),
    .inf_seen      (inf_seen),
    .clip_seen     (clip_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_t rect_of(coef_t x, coef_t y, size_t w, size_t h, logic inf);
    in_t r;
    r.rect_x   = x;
    r.rect_y   = y;
    r.rect_w   = w;
    r.rect_h   = h;
    r.rect_inf = inf;
    return r;
  endfunction

  function automatic coef_t pick_coord();
    case ($urandom_range(9))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(32'h3FFFFF) - 32'h200000;
    endcase
  endfunction

  function automatic size_t pick_size();
    case ($urandom_range(9))
      0:       return SMAX;
      1:       return '0;
      2, 3:    return 31'($urandom);
      default: return 31'($urandom_range(32'h3FFFFF));
    endcase
  endfunction

  function automatic in_t random_rect();
    return rect_of(pick_coord(), pick_coord(), pick_size(), pick_size(),
                   $urandom_range(19) == 0);
  endfunction

  // within +-4.0
  function automatic coef_t small_coef();
    return $urandom_range(32'h7FFFF) - 32'h40000;
  endfunction

  // within +-2^24 whole coordinate units
  function automatic coef_t small_shift();
    return $urandom_range(32'h1FFFFFF) - 32'h1000000;
  endfunction

  // hold start until the beat is taken, then idle at random
  task automatic push_rect(in_t r, int idle_pct);
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    n_rects++;
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= random_rect();
      @(posedge clk);
    end
  endtask

  // drop start and wait until every box is back
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (boxes_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [4:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_matrix(coef_t xx, coef_t xy, coef_t yx, coef_t yy,
                            coef_t sx, coef_t sy);
    apb_write(5'(4 * REG_COEF_XX), xx);
    apb_write(5'(4 * REG_COEF_XY), xy);
    apb_write(5'(4 * REG_COEF_YX), yx);
    apb_write(5'(4 * REG_COEF_YY), yy);
    apb_write(5'(4 * REG_SHIFT_X), sx);
    apb_write(5'(4 * REG_SHIFT_Y), sy);
    n_settings++;
  endtask

  task automatic load_phase_matrix(int k);
    case (k)
      0:  set_matrix(Q_ONE, '0, '0, Q_ONE, CMAX, CMIN);
      1:  set_matrix(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      2: begin
        set_matrix(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        // unmapped addresses must leave the matrix alone
        apb_write(5'(4 * NUM_CFG_REGS), $urandom);
        apb_write(5'(4 * NUM_CFG_REGS + 4), $urandom);
      end
      3:  set_matrix(small_coef(), small_coef(), small_coef(), small_coef(),
                     small_shift(), small_shift());
      // rotation by 30 degrees
      4:  set_matrix(32'sd56756, -32'sd32768, 32'sd32768, 32'sd56756,
                     small_shift(), small_shift());
      6:  set_matrix('0, '0, '0, '0, $urandom, $urandom);
      7:  set_matrix('0, Q_ONE, -Q_ONE, '0, '0, '0);
      // tiny coefficients: almost everything rounds
      9:  set_matrix(32'sd1, -32'sd1, 32'sd3, 32'sd2, small_shift(), small_shift());
      5, 8, 11: set_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      default: set_matrix(small_coef(), small_coef(), small_coef(), small_coef(),
                          small_shift(), small_shift());
    endcase
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    n_settings = 1;

    // identity matrix from reset: field extremes and infinite input
    push_rect(rect_of('0, '0, '0, '0, 1'b0), 0);
    push_rect(rect_of(Q_ONE, Q_ONE, 31'h10000, 31'h10000, 1'b0), 0);
    push_rect(rect_of(CMIN, CMIN, '0, '0, 1'b0), 29);
    push_rect(rect_of(CMAX, CMAX, '0, '0, 1'b0), 0);
    push_rect(rect_of(CMAX, CMAX, SMAX, SMAX, 1'b0), 65);
    push_rect(rect_of(CMIN, CMIN, SMAX, SMAX, 1'b0), 0);
    push_rect(rect_of(-32'sh18000, 32'sh24000, 31'h30000, 31'h8000, 1'b0), 0);
    push_rect(rect_of('0, '0, '0, '0, 1'b1), 29);
    push_rect(rect_of(CMAX, CMIN, SMAX, 31'h1234567, 1'b1), 0);
    push_rect(rect_of(CMIN, CMAX, SMAX, '0, 1'b0), 0);
    quiesce();

    // half-scale 45-degree rotation: odd raw coordinates land exactly on rounding ties
    set_matrix(32'sh8000, 32'sh8000, -32'sh8000, 32'sh8000, '0, '0);
    push_rect(rect_of(32'sd1, '0, 31'd2, '0, 1'b0), 0);
    push_rect(rect_of(-32'sd1, '0, '0, '0, 1'b0), 0);
    push_rect(rect_of(-32'sd3, -32'sd1, 31'd1, 31'd1, 1'b0), 65);
    push_rect(rect_of(32'sd3, 32'sd1, '0, '0, 1'b0), 0);
    push_rect(rect_of(CMIN, CMIN, SMAX, SMAX, 1'b0), 0);
    push_rect(rect_of(CMAX, CMAX, SMAX, SMAX, 1'b0), 29);
    push_rect(rect_of(CMAX, CMIN, '0, SMAX, 1'b0), 0);
    push_rect(rect_of(CMIN, CMAX, SMAX, SMAX, 1'b1), 0);

    for (int k = 0; k < NUM_PHASES; k++) begin
      quiesce();
      load_phase_matrix(k);
      for (int n = 0; n < RECTS_PER_PH; n++) begin
        push_rect(random_rect(), IDLE_PCT[k % 4]);
      end
    end
    quiesce();

    $display("summary: %0d rectangles under %0d matrix settings, %0d boxes checked",
             n_rects, n_settings, boxes_seen);
    $display("summary: %0d infinite, %0d clipped, %0d mismatches",
             inf_seen, clip_seen, fail_count);
    if (fail_count == 0 && boxes_waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
